// ----- rtl/nsp_pkg.sv -----
package nsp_pkg;

  localparam int ID_W        = 8;
  localparam int TIME_W      = 48;
  localparam int HIT_W       = 32;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_OUT_W = 11;

  // command codes; read and the spare code both fall through to a plain lookup
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic              is_start;
    logic              is_stop;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] ts;
  } item_t;

endpackage

// ----- rtl/nsp_front.sv -----
module nsp_front #(
  parameter int NUM_SECTIONS = 256
) (
  input  logic                                    push,
  input  logic [nsp_pkg::CMD_W-1:0]               cmd,
  input  logic [nsp_pkg::ID_W-1:0]                section_id,
  input  logic [nsp_pkg::TIME_W-1:0]              timestamp,
  input  logic                                    q_full,
  input  logic                                    clearing,
  output logic                                    full,
  output logic                                    q_wr,
  output nsp_pkg::item_t                          item,
  output logic [$clog2(NUM_SECTIONS)-1:0]         idx
);

  localparam int SEC_W   = $clog2(NUM_SECTIONS);
  localparam int NUM_IDS = 1 << nsp_pkg::ID_W;

  // id to table row, folded at elaboration
  logic [SEC_W-1:0] idx_lut [NUM_IDS];

  for (genvar g = 0; g < NUM_IDS; g++) begin : g_lut
    assign idx_lut[g] = SEC_W'(g % NUM_SECTIONS);
  end

  assign full = q_full || clearing;
  assign q_wr = push && !full;

  always_comb begin
    item.is_start = (cmd == nsp_pkg::CMD_START);
    item.is_stop  = (cmd == nsp_pkg::CMD_STOP);
    item.id       = section_id;
    item.ts       = timestamp;
    idx           = idx_lut[section_id];
  end

endmodule

// ----- rtl/nsp_queue.sv -----
module nsp_queue #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         valid
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ----- rtl/nsp_back.sv -----
module nsp_back #(
  parameter int NUM_SECTIONS = 256,
  parameter int STACK_DEPTH  = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  nsp_pkg::item_t                       q_item,
  input  logic [$clog2(NUM_SECTIONS)-1:0]      q_idx,
  output logic                                 q_rd,
  output logic                                 clearing,
  input  logic                                 pop,
  output logic                                 empty,
  output logic [nsp_pkg::HIT_W-1:0]            hit_count,
  output logic [nsp_pkg::TIME_W-1:0]           total_time,
  output logic [nsp_pkg::DEPTH_OUT_W-1:0]      stack_depth,
  output logic [nsp_pkg::STATUS_W-1:0]         status
);

  localparam int SEC_W    = $clog2(NUM_SECTIONS);
  localparam int AW       = $clog2(STACK_DEPTH);
  localparam int DW       = $clog2(STACK_DEPTH + 1);
  localparam int ID_W     = nsp_pkg::ID_W;
  localparam int SW       = ID_W + SEC_W;
  localparam int HIT_W    = nsp_pkg::HIT_W;
  localparam int TIME_W   = nsp_pkg::TIME_W;
  localparam int DOW      = nsp_pkg::DEPTH_OUT_W;
  localparam logic [SEC_W-1:0] LAST_SEC  = SEC_W'(NUM_SECTIONS - 1);
  localparam logic [DW-1:0]    DEPTH_CAP = DW'(STACK_DEPTH);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_START, S_WALK, S_TOP, S_FIN} state_t;

  state_t state;

  // stores
  logic [HIT_W-1:0]  hits_mem [NUM_SECTIONS];
  logic [TIME_W-1:0] time_mem [NUM_SECTIONS];
  logic [SW-1:0]     stk_mem  [STACK_DEPTH];

  logic [HIT_W-1:0]  hits_rd;
  logic [TIME_W-1:0] time_a_rd;
  logic [TIME_W-1:0] time_b_rd;
  logic [SW-1:0]     stk_rd;

  logic              hits_we, hits_re;
  logic [SEC_W-1:0]  hits_wa, hits_ra;
  logic [HIT_W-1:0]  hits_wd;
  logic              time_we, time_re;
  logic [SEC_W-1:0]  time_wa, time_ra_a, time_ra_b;
  logic [TIME_W-1:0] time_wd;
  logic              stk_we, stk_re;
  logic [AW-1:0]     stk_wa, stk_ra;
  logic [SW-1:0]     stk_wd;

  // control and working registers
  logic [SEC_W-1:0]  clr_ptr;
  logic [DW-1:0]     depth;
  logic [TIME_W-1:0] last_time;
  logic [SW-1:0]     top_ent;
  nsp_pkg::item_t    cur;
  logic [SEC_W-1:0]  cur_idx;
  logic [TIME_W-1:0] elapsed;
  logic [AW-1:0]     ptr;
  logic [nsp_pkg::STATUS_W-1:0] status_r;
  logic              out_valid;

  logic              dispatch;
  logic              has_top;
  logic              can_push;
  logic              match;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     ptr_dec;
  logic [SEC_W-1:0]  top_idx;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] stop_time;

  assign clearing   = (state == S_CLEAR);
  assign empty      = !out_valid;
  assign dispatch   = (state == S_IDLE) && q_valid && (!out_valid || pop);
  assign q_rd       = dispatch;
  assign has_top    = (depth != '0);
  assign can_push   = (depth < DEPTH_CAP);
  assign top_addr   = AW'(depth - DW'(1));
  assign ptr_dec    = ptr - AW'(1);
  assign match      = (stk_rd[SW-1 -: ID_W] == cur.id);
  assign top_idx    = top_ent[SEC_W-1:0];
  assign start_time = time_b_rd + elapsed;
  assign stop_time  = time_a_rd + elapsed;

  always_ff @(posedge clk) begin
    if (hits_we) begin
      hits_mem[hits_wa] <= hits_wd;
    end
    if (hits_re) begin
      hits_rd <= hits_mem[hits_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (time_we) begin
      time_mem[time_wa] <= time_wd;
    end
    if (time_re) begin
      time_a_rd <= time_mem[time_ra_a];
      time_b_rd <= time_mem[time_ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd <= stk_mem[stk_ra];
    end
  end

  always_comb begin
    hits_we   = 1'b0;
    hits_wa   = cur_idx;
    hits_wd   = hits_rd + HIT_W'(1);
    hits_re   = 1'b0;
    hits_ra   = q_idx;
    time_we   = 1'b0;
    time_wa   = cur_idx;
    time_wd   = stop_time;
    time_re   = 1'b0;
    time_ra_a = q_idx;
    time_ra_b = top_idx;
    stk_we    = 1'b0;
    stk_wa    = AW'(depth);
    stk_wd    = {cur.id, cur_idx};
    stk_re    = 1'b0;
    stk_ra    = ptr_dec;
    case (state)
      S_CLEAR: begin
        hits_we = 1'b1;
        hits_wa = clr_ptr;
        hits_wd = '0;
        time_we = 1'b1;
        time_wa = clr_ptr;
        time_wd = '0;
      end
      S_IDLE: begin
        if (dispatch) begin
          hits_re = 1'b1;
          time_re = 1'b1;
          if (q_item.is_stop && has_top) begin
            stk_re = 1'b1;
            stk_ra = top_addr;
          end
        end
      end
      S_START: begin
        hits_we = 1'b1;
        // charge the section that was running
        if (has_top) begin
          time_we = 1'b1;
          time_wa = top_idx;
          time_wd = start_time;
        end
        stk_we = can_push;
      end
      S_WALK: begin
        stk_re = (ptr != '0);
      end
      S_FIN: begin
        time_we = cur.is_stop;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_ptr   <= '0;
      depth     <= '0;
      last_time <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + SEC_W'(1);
          if (clr_ptr == LAST_SEC) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (dispatch) begin
            cur      <= q_item;
            cur_idx  <= q_idx;
            elapsed  <= q_item.ts - last_time;
            ptr      <= top_addr;
            status_r <= (q_item.is_stop && !has_top) ? nsp_pkg::ST_EMPTY : nsp_pkg::ST_OK;
            if (q_item.is_start) begin
              state <= S_START;
            end else if (q_item.is_stop && has_top) begin
              state <= S_WALK;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_START: begin
          last_time <= cur.ts;
          out_valid <= 1'b1;
          hit_count <= hits_rd + HIT_W'(1);
          total_time <= (has_top && top_idx == cur_idx) ? start_time : time_a_rd;
          if (can_push) begin
            depth       <= depth + DW'(1);
            top_ent     <= {cur.id, cur_idx};
            stack_depth <= DOW'(depth + DW'(1));
            status      <= nsp_pkg::ST_OK;
          end else begin
            stack_depth <= DOW'(depth);
            status      <= nsp_pkg::ST_FULL;
          end
          state <= S_IDLE;
        end
        S_WALK: begin
          // one stack word compared per cycle, top down
          if (match) begin
            depth <= DW'(ptr);
            state <= (ptr != '0) ? S_TOP : S_FIN;
          end else if (ptr == '0) begin
            depth    <= '0;
            status_r <= nsp_pkg::ST_NOT_FOUND;
            state    <= S_FIN;
          end else begin
            ptr <= ptr_dec;
          end
        end
        S_TOP: begin
          top_ent <= stk_rd;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (cur.is_stop) begin
            last_time <= cur.ts;
          end
          out_valid   <= 1'b1;
          hit_count   <= hits_rd;
          total_time  <= cur.is_stop ? stop_time : time_a_rd;
          stack_depth <= DOW'(depth);
          status      <= status_r;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/nested_section_profiler_unit.sv -----
// a start reads the section tables on accept, then updates them and registers its result;
// a read, or a stop on an empty stack, goes from the table read straight to its result;
// any other stop reads the top stack word, then walks the stack top down, one memory word
// per cycle, to the match or the bottom. No new item is taken until the last one is done
// and the result register is free or being popped. reset is synchronous; the section tables
// are then swept to zero one row at a time, with full held high until the sweep ends
module nested_section_profiler_unit #(
  parameter int NUM_SECTIONS = 256,
  parameter int STACK_DEPTH  = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [nsp_pkg::CMD_W-1:0]            cmd,
  input  logic [nsp_pkg::ID_W-1:0]             section_id,
  input  logic [nsp_pkg::TIME_W-1:0]           timestamp,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [nsp_pkg::HIT_W-1:0]            hit_count,
  output logic [nsp_pkg::TIME_W-1:0]           total_time,
  output logic [nsp_pkg::DEPTH_OUT_W-1:0]      stack_depth,
  output logic [nsp_pkg::STATUS_W-1:0]         status
);

  localparam int SEC_W = $clog2(NUM_SECTIONS);
  localparam int QW    = $bits(nsp_pkg::item_t) + SEC_W;

  logic             q_full;
  logic             q_wr;
  logic             q_rd;
  logic             q_valid;
  logic             clearing;
  nsp_pkg::item_t   f_item;
  logic [SEC_W-1:0] f_idx;
  nsp_pkg::item_t   q_item;
  logic [SEC_W-1:0] q_idx;
  logic [QW-1:0]    q_rdata;

  nsp_front #(
    .NUM_SECTIONS (NUM_SECTIONS)
  ) u_front (
    .push       (push),
    .cmd        (cmd),
    .section_id (section_id),
    .timestamp  (timestamp),
    .q_full     (q_full),
    .clearing   (clearing),
    .full       (full),
    .q_wr       (q_wr),
    .item       (f_item),
    .idx        (f_idx)
  );

  // short word queue between classification and execution
  nsp_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata ({f_item, f_idx}),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .valid (q_valid)
  );

  assign q_item = q_rdata[QW-1 -: $bits(nsp_pkg::item_t)];
  assign q_idx  = q_rdata[SEC_W-1:0];

  nsp_back #(
    .NUM_SECTIONS (NUM_SECTIONS),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_idx       (q_idx),
    .q_rd        (q_rd),
    .clearing    (clearing),
    .pop         (pop),
    .empty       (empty),
    .hit_count   (hit_count),
    .total_time  (total_time),
    .stack_depth (stack_depth),
    .status      (status)
  );

endmodule

// ----- tb/nested_section_profiler_unit_tb.sv -----
`timescale 1ns / 100ps

module nested_section_profiler_unit_tb;

  localparam int TABLE_SIZE  = 256;
  localparam int STACK_WORDS = 1024;

  // read and the spare code are plain lookups in the block
  localparam logic [nsp_pkg::CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [nsp_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic [nsp_pkg::HIT_W-1:0]       hits;
    logic [nsp_pkg::TIME_W-1:0]      ticks;
    logic [nsp_pkg::DEPTH_OUT_W-1:0] depth;
    logic [nsp_pkg::STATUS_W-1:0]    st;
  } totals_t;

  class section_totals_board;
    logic [nsp_pkg::ID_W-1:0]   open_ids [STACK_WORDS];
    int unsigned                open_depth;
    logic [nsp_pkg::TIME_W-1:0] last_stamp;
    logic [nsp_pkg::HIT_W-1:0]  hit_tab [TABLE_SIZE];
    logic [nsp_pkg::TIME_W-1:0] time_tab [TABLE_SIZE];
    totals_t                    pending_totals [$];
    int unsigned                errors;

    function new();
      open_depth = 0;
      last_stamp = '0;
      errors = 0;
      foreach (hit_tab[i]) hit_tab[i] = '0;
      foreach (time_tab[i]) time_tab[i] = '0;
    endfunction

    function void charge(int unsigned idx, logic [nsp_pkg::TIME_W-1:0] now);
      logic [nsp_pkg::TIME_W-1:0] elapsed;
      elapsed = now - last_stamp;
      time_tab[idx] = time_tab[idx] + elapsed;
    endfunction

    function void record_item(logic [nsp_pkg::CMD_W-1:0] c, logic [nsp_pkg::ID_W-1:0] id,
                              logic [nsp_pkg::TIME_W-1:0] now);
      totals_t t;
      logic [nsp_pkg::STATUS_W-1:0] st;
      int unsigned k;
      bit found;
      st = nsp_pkg::ST_OK;
      if (c == nsp_pkg::CMD_START) begin
        if (open_depth > 0) charge(open_ids[open_depth-1], now);
        if (open_depth < STACK_WORDS) begin
          open_ids[open_depth] = id;
          open_depth++;
        end else begin
          st = nsp_pkg::ST_FULL;
        end
        hit_tab[id] = hit_tab[id] + 1'b1;
        last_stamp = now;
      end else if (c == nsp_pkg::CMD_STOP) begin
        if (open_depth == 0) begin
          st = nsp_pkg::ST_EMPTY;
        end else begin
          k = open_depth;
          found = 1'b0;
          while (k > 0) begin
            k--;
            if (open_ids[k] == id) begin
              found = 1'b1;
              break;
            end
          end
          if (found) begin
            open_depth = k;
          end else begin
            open_depth = 0;
            st = nsp_pkg::ST_NOT_FOUND;
          end
        end
        charge(id, now);
        last_stamp = now;
      end
      t.hits = hit_tab[id];
      t.ticks = time_tab[id];
      t.depth = open_depth[nsp_pkg::DEPTH_OUT_W-1:0];
      t.st = st;
      pending_totals.push_back(t);
    endfunction

    function void check_word(logic [nsp_pkg::HIT_W-1:0] hits,
                             logic [nsp_pkg::TIME_W-1:0] ticks,
                             logic [nsp_pkg::DEPTH_OUT_W-1:0] depth,
                             logic [nsp_pkg::STATUS_W-1:0] st);
      totals_t t;
      if (pending_totals.size() == 0) begin
        $error("result word with no item waiting");
        errors++;
        return;
      end
      t = pending_totals.pop_front();
      if (hits !== t.hits) begin
        $error("hit_count expected %0d actual %0d", t.hits, hits);
        errors++;
      end
      if (ticks !== t.ticks) begin
        $error("total_time expected %0h actual %0h", t.ticks, ticks);
        errors++;
      end
      if (depth !== t.depth) begin
        $error("stack_depth expected %0d actual %0d", t.depth, depth);
        errors++;
      end
      if (st !== t.st) begin
        $error("status expected %0d actual %0d", t.st, st);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            push = 1'b0;
  logic                            full;
  logic [nsp_pkg::CMD_W-1:0]       cmd = '0;
  logic [nsp_pkg::ID_W-1:0]        section_id = '0;
  logic [nsp_pkg::TIME_W-1:0]      timestamp = '0;
  logic                            empty;
  logic                            pop = 1'b0;
  logic [nsp_pkg::HIT_W-1:0]       hit_count;
  logic [nsp_pkg::TIME_W-1:0]      total_time;
  logic [nsp_pkg::DEPTH_OUT_W-1:0] stack_depth;
  logic [nsp_pkg::STATUS_W-1:0]    status;

  int unsigned                send_idle_pct = 0;
  int unsigned                recv_stall_pct = 0;
  int unsigned                hold_ticks = 0;
  int unsigned                sent_items = 0;
  logic [nsp_pkg::TIME_W-1:0] clock_ticks = '0;

  section_totals_board board = new();

  nested_section_profiler_unit #(
    .NUM_SECTIONS(TABLE_SIZE),
    .STACK_DEPTH (STACK_WORDS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .section_id (section_id),
    .timestamp  (timestamp),
    .empty      (empty),
    .pop        (pop),
    .hit_count  (hit_count),
    .total_time (total_time),
    .stack_depth(stack_depth),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_ticks > 0) begin
        pop <= 1'b0;
        hold_ticks--;
      end else begin
        pop <= !rst && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) board.record_item(cmd, section_id, timestamp);
      if (pop && !empty) board.check_word(hit_count, total_time, stack_depth, status);
    end
  end

  function automatic logic [nsp_pkg::TIME_W-1:0] next_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    // mostly moves forward, now and then jumps anywhere
    if ($urandom_range(19) == 0) clock_ticks = r[nsp_pkg::TIME_W-1:0];
    else clock_ticks = clock_ticks + r[9:0];
    return clock_ticks;
  endfunction

  task automatic send_item(input logic [nsp_pkg::CMD_W-1:0] c,
                           input logic [nsp_pkg::ID_W-1:0] id,
                           input logic [nsp_pkg::TIME_W-1:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    section_id <= id;
    timestamp <= ts;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_items++;
  endtask

  task automatic run_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned levels;
    logic [nsp_pkg::ID_W-1:0] opened [$];
    logic [nsp_pkg::ID_W-1:0] id;
    logic [63:0] r;
    stop_at = sent_items + count;
    while (sent_items < stop_at) begin
      if ($urandom_range(99) < 15) begin
        r = {$urandom, $urandom};
        send_item(r[1:0], r[9:2], r[57:10]);
      end else begin
        levels = $urandom_range(1, 6);
        opened.delete();
        repeat (levels) begin
          // small id pool half the time so ids repeat on the stack
          id = ($urandom_range(1) == 1) ? 8'($urandom_range(15)) : 8'($urandom);
          send_item(nsp_pkg::CMD_START, id, next_stamp());
          opened.push_back(id);
          if ($urandom_range(3) == 0)
            send_item(CMD_READ, opened[$urandom_range(opened.size() - 1)], next_stamp());
        end
        while (opened.size() > 0) begin
          // now and then close an outer section so the inner one unwinds with it
          if (opened.size() > 1 && $urandom_range(9) == 0) void'(opened.pop_back());
          id = opened.pop_back();
          send_item(nsp_pkg::CMD_STOP, id, next_stamp());
        end
      end
    end
  endtask

  initial begin
    logic [nsp_pkg::ID_W-1:0] id;
    logic [63:0] r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // lookups on cleared tables, stop on empty stack
    send_item(CMD_READ,           8'h00, 48'h0);
    send_item(CMD_SPARE,          8'hFF, 48'hFFFF_FFFF_FFFF);
    send_item(nsp_pkg::CMD_STOP,  8'h55, 48'h10);
    // nesting, timestamp wrap, match at top, absent id
    send_item(nsp_pkg::CMD_START, 8'h00, 48'h0);
    send_item(nsp_pkg::CMD_START, 8'hFF, 48'hFFFF_FFFF_FFFF);
    send_item(nsp_pkg::CMD_START, 8'hAA, 48'h5);
    send_item(nsp_pkg::CMD_STOP,  8'hAA, 48'h9);
    send_item(nsp_pkg::CMD_START, 8'h03, 48'h20);
    send_item(nsp_pkg::CMD_STOP,  8'h77, 48'h30);
    // repeated id: topmost match first, then the bottom one
    send_item(nsp_pkg::CMD_START, 8'h07, 48'h40);
    send_item(nsp_pkg::CMD_START, 8'h07, 48'h8000_0000_0000);
    send_item(nsp_pkg::CMD_STOP,  8'h07, 48'h7FFF_FFFF_FFFF);
    send_item(nsp_pkg::CMD_STOP,  8'h07, 48'h50);
    send_item(nsp_pkg::CMD_STOP,  8'h07, 48'h60);
    send_item(CMD_READ,           8'hFF, 48'h70);
    send_item(CMD_READ,           8'h00, 48'hFFFF_FFFF_FFFF);
    send_item(CMD_SPARE,          8'hAA, 48'h0);
    send_item(CMD_READ,           8'h55, 48'h1);

    // fill the stack, start on a full stack, then stop the bottom entry
    send_item(nsp_pkg::CMD_START, 8'hC3, next_stamp());
    repeat (STACK_WORDS - 1) begin
      id = 8'($urandom);
      if (id == 8'hC3) id = 8'h3C;
      r = {$urandom, $urandom};
      send_item(nsp_pkg::CMD_START, id, r[nsp_pkg::TIME_W-1:0]);
    end
    send_item(nsp_pkg::CMD_START, 8'hC3, next_stamp());
    send_item(nsp_pkg::CMD_START, 8'h5A, next_stamp());
    send_item(CMD_READ,           8'hC3, next_stamp());
    send_item(nsp_pkg::CMD_STOP,  8'hC3, next_stamp());

    // first run: no idling, with a long receiver hold-off so the block backs up
    hold_ticks = 400;
    run_traffic(140);
    send_idle_pct = 51;
    recv_stall_pct = 0;
    run_traffic(140);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    run_traffic(140);
    send_idle_pct = 17;
    recv_stall_pct = 17;
    run_traffic(140);
    push <= 1'b0;

    while (board.pending_totals.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
